/* rtl/gn2d_pkg.sv */
// Package: constants and tables for the 2D gradient noise pipeline.
package gn2d_pkg;

  localparam int FracBitsDefault = 16;
  localparam int ScaleK = 72090;
  localparam int OutW = 18;
  localparam logic [9:0] SeedMulX = 10'd1013;
  localparam logic [10:0] SeedMulY = 11'd1619;
  localparam logic [1:0] RegSeed = 2'd0;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,
    8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,
    8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,
    8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,
    8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,
    8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,
    8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,
    8'd230,8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,
    8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,
    8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,
    8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,
    8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,
    8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,
    8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,
    8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,
    8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,
    8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,
    8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
    8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  // gradient component codes: 0 zero, 1 plus, 2 minus
  localparam logic [1:0] GX [16] = '{2'd1,2'd2,2'd1,2'd2,2'd1,2'd2,2'd1,2'd2,
                                     2'd0,2'd0,2'd0,2'd0,2'd1,2'd2,2'd0,2'd0};
  localparam logic [1:0] GY [16] = '{2'd1,2'd1,2'd2,2'd2,2'd0,2'd0,2'd0,2'd0,
                                     2'd1,2'd2,2'd1,2'd2,2'd1,2'd1,2'd2,2'd2};
  localparam logic [1:0] GZero = 2'd0;
  localparam logic [1:0] GPlus = 2'd1;

endpackage

/* rtl/gn2d_hash.sv */
// Lattice hashing and corner dot products, two register stages.
module gn2d_hash import gn2d_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [7:0]            x0_i,
  input  logic [7:0]            y0_i,
  input  logic [FRAC_BITS-1:0]  fx_i,
  input  logic [FRAC_BITS-1:0]  fy_i,
  output logic signed [FRAC_BITS+2:0] n_o [4]
);
  localparam int NW = FRAC_BITS + 3;

  logic [7:0] py0_q, py1_q, x0_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic signed [NW-1:0] n_q [4];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      py0_q <= PERM[y0_i];
      py1_q <= PERM[8'(y0_i + 8'd1)];
      x0_q  <= x0_i;
      fx_q  <= fx_i;
      fy_q  <= fy_i;
    end
  end

  function automatic logic signed [NW-1:0] term(input logic [1:0] g,
                                                 input logic signed [NW-1:0] d);
    logic signed [NW-1:0] r;
    r = '0;
    if (g == GPlus) r = d;
    else if (g != GZero) r = -d;
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        logic [7:0] cx, py;
        logic [3:0] h;
        logic signed [NW-1:0] dx, dy;
        cx = (k % 2 == 1) ? 8'(x0_q + 8'd1) : x0_q;
        py = (k >= 2) ? py1_q : py0_q;
        h  = PERM[8'(cx + py)][3:0];
        dx = $signed({3'b000, fx_q}) - ((k % 2 == 1) ? (NW'(1) <<< FRAC_BITS) : NW'(0));
        dy = $signed({3'b000, fy_q}) - ((k >= 2) ? (NW'(1) <<< FRAC_BITS) : NW'(0));
        n_q[k] <= term(GX[h], dx) + term(GY[h], dy);
      end
    end
  end

  assign n_o = n_q;
endmodule

/* rtl/gn2d_fade.sv */
// Quintic fade of one fraction, four register stages.
module gn2d_fade import gn2d_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FRAC_BITS:0]   f_o
);
  localparam int W = FRAC_BITS + 6;
  localparam int PW = 2 * W;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (FRAC_BITS - 1);

  logic signed [W-1:0] t1_q, t2_q, a_q, c_q, sq_q, cu_q;
  logic signed [W-1:0] c2_q;
  logic [FRAC_BITS:0] f_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: a = 6t - 15
      a_q  <= W'($signed({6'd0, t_i}) * 6) - W'(15 <<< FRAC_BITS);
      t1_q <= $signed({6'd0, t_i});
      // stage 2: c = round(a*t) + 10, t2 = round(t*t)
      c_q  <= W'((PW'(a_q) * PW'(t1_q) + Half) >>> FRAC_BITS) + W'(10 <<< FRAC_BITS);
      sq_q <= W'((PW'(t1_q) * PW'(t1_q) + Half) >>> FRAC_BITS);
      t2_q <= t1_q;
      // stage 3: t3 = round(t2*t)
      cu_q <= W'((PW'(sq_q) * PW'(t2_q) + Half) >>> FRAC_BITS);
      c2_q <= c_q;
      // stage 4: fade
      f_q  <= (FRAC_BITS+1)'((PW'(cu_q) * PW'(c2_q) + Half) >>> FRAC_BITS);
    end
  end
  assign f_o = f_q;
endmodule

/* rtl/gn2d_blend.sv */
// Bilinear blend with fade weights, scale and saturate, three register stages.
module gn2d_blend import gn2d_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [FRAC_BITS+2:0] n_i [4],
  input  logic [FRAC_BITS:0]          u_i,
  input  logic [FRAC_BITS:0]          v_i,
  output logic signed [OutW-1:0]      r_o
);
  localparam int W = FRAC_BITS + 4;
  localparam int PW = 2 * W + 2;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] OMax = PW'((1 <<< (OutW - 1)) - 1);
  localparam logic signed [PW-1:0] OMin = -(PW'(1) <<< (OutW - 1));

  logic signed [W-1:0] r0_q, r1_q, val_q;
  logic [FRAC_BITS:0] v_q;
  logic signed [OutW-1:0] r_q;

  function automatic logic signed [W-1:0] mix(input logic [FRAC_BITS:0] t,
                                              input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'($signed({1'b0, t})) * PW'(b - a);
    return a + W'((p + Half) >>> FRAC_BITS);
  endfunction

  always_ff @(posedge clk_i) begin
    logic signed [PW-1:0] s;
    if (en_i) begin
      r0_q  <= mix(u_i, W'(n_i[0]), W'(n_i[1]));
      r1_q  <= mix(u_i, W'(n_i[2]), W'(n_i[3]));
      v_q   <= v_i;
      val_q <= mix(v_q, r0_q, r1_q);
      s = (PW'(val_q) * PW'(ScaleK) + Half) >>> FRAC_BITS;
      if (s > OMax) r_q <= OutW'(OMax);
      else if (s < OMin) r_q <= OutW'(OMin);
      else r_q <= OutW'(s);
    end
  end
  assign r_o = r_q;
endmodule

/* rtl/gradient_noise_2d.sv */
// Top level: 2D gradient noise pipeline with stream ports and APB seed register.
//  channel | direction | handshake          | payload
//  s_axis  | in        | tvalid/tready      | x_coord, y_coord
//  m_axis  | out       | tvalid/tready      | noise_value
//  apb     | cfg       | psel/penable/pready| noise_seed
// One item per cycle while the output item is not held; eight register stages:
// one lattice stage, four fade stages (the multiplier chain sets the depth),
// three blend and scale stages.
// Reset clears valid bits and the seed.
// The whole pipeline holds while the output item waits and tready is low.
module gradient_noise_2d import gn2d_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // x_coord[31:0], y_coord[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // noise_value[17:0], zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int Depth = 8;

  logic [31:0] seed_q;
  logic [Depth-1:0] vld_q;
  logic en;
  logic [7:0] sx, sy, x0_q, y0_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [FRAC_BITS:0] u, v;
  logic signed [FRAC_BITS+2:0] n [4];
  logic signed [FRAC_BITS+2:0] nd_q [4];
  logic signed [FRAC_BITS+2:0] nd2_q [4];
  logic signed [OutW-1:0] r;

  assign pready = 1'b1;
  assign prdata = (paddr == RegSeed) ? seed_q : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegSeed) begin
      seed_q <= pwdata;
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
    end
  end

  assign sx = 8'(seed_q[7:0] * SeedMulX[7:0]);
  assign sy = 8'(seed_q[7:0] * SeedMulY[7:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= s_axis_tdata[FRAC_BITS +: 8] + sx;
      y0_q <= s_axis_tdata[32+FRAC_BITS +: 8] + sy;
      fx_q <= s_axis_tdata[FRAC_BITS-1:0];
      fy_q <= s_axis_tdata[32 +: FRAC_BITS];
    end
  end

  gn2d_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
    .clk_i, .en_i(en), .x0_i(x0_q), .y0_i(y0_q), .fx_i(fx_q), .fy_i(fy_q), .n_o(n)
  );
  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk_i, .en_i(en), .t_i(fx_q), .f_o(u)
  );
  gn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk_i, .en_i(en), .t_i(fy_q), .f_o(v)
  );

  // align dot products with fade (hash 2 stages, fade 4)
  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_q  <= n;
      nd2_q <= nd_q;
    end
  end

  gn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk_i, .en_i(en), .n_i(nd2_q), .u_i(u), .v_i(v), .r_o(r)
  );

  assign m_axis_tdata = {6'd0, r};
endmodule

/* rtl/gn2d_checker.sv */
// Port-level checker for the noise pipeline, bound to the top level.
module gn2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        pready
);
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready)) else $error("ready");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("hold");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tdata[23:18] == 6'd0) else $error("fill");
  a_pready: assert property (@(posedge clk_i) pready) else $error("pready");
endmodule

bind gradient_noise_2d gn2d_checker u_chk (.*);

/* test/gn2d_checker.sv */
// Checker: predicts gradient noise samples and compares them with the output stream.
`timescale 1ns / 1ps
module gn2d_scoreboard import gn2d_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending_count
);
  localparam int FB = FracBitsDefault;
  localparam longint ONE = longint'(1) << FB;

  logic [31:0]      seed_q;
  logic [17:0]      noise_q[$];

  function automatic longint rshift_round(longint v);
    return (v + (longint'(1) << (FB - 1))) >>> FB;
  endfunction

  function automatic longint fade(longint t);
    longint a, c, t2, t3;
    a = 6 * t - 15 * ONE;
    c = rshift_round(a * t) + 10 * ONE;
    t2 = rshift_round(t * t);
    t3 = rshift_round(t2 * t);
    return rshift_round(t3 * c);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + rshift_round(t * (b - a));
  endfunction

  function automatic longint grad_dot(logic [7:0] cx, logic [7:0] cy, longint dx, longint dy);
    logic [7:0] idx;
    logic [3:0] h;
    longint gx, gy;
    idx = cx + PERM[cy];
    h = PERM[idx][3:0];
    gx = (h inside {8, 9, 10, 11, 14, 15}) ? 0 : (h[0] ? -1 : 1);
    gy = (h inside {4, 5, 6, 7}) ? 0 :
         ((h inside {2, 3, 9, 11, 14, 15}) ? -1 : 1);
    return gx * dx + gy * dy;
  endfunction

  function automatic logic [17:0] noise_at(logic [31:0] xr, logic [31:0] yr, logic [31:0] s);
    longint fx, fy, u, v, r0, r1, val, r;
    logic [7:0] x0, y0, sx, sy;
    logic [63:0] px, py;
    px = 64'(s) * 1013;
    py = 64'(s) * 1619;
    sx = px[7:0];
    sy = py[7:0];
    fx = longint'(xr[FB-1:0]);
    fy = longint'(yr[FB-1:0]);
    x0 = xr[FB +: 8] + sx;
    y0 = yr[FB +: 8] + sy;
    u = fade(fx);
    v = fade(fy);
    r0 = blend(u, grad_dot(x0, y0, fx, fy), grad_dot(x0 + 8'd1, y0, fx - ONE, fy));
    r1 = blend(u, grad_dot(x0, y0 + 8'd1, fx, fy - ONE),
               grad_dot(x0 + 8'd1, y0 + 8'd1, fx - ONE, fy - ONE));
    val = blend(v, r0, r1);
    r = rshift_round(val * ScaleK);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[17:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [17:0] want;
    if (!rst_ni) begin
      seed_q <= '0;
      fail_count <= 0;
      pending_count <= 0;
      noise_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == RegSeed) seed_q <= pwdata;
      if (s_axis_tvalid && s_axis_tready)
        noise_q.push_back(noise_at(s_axis_tdata[31:0], s_axis_tdata[63:32], seed_q));
      if (m_axis_tvalid && m_axis_tready) begin
        if (noise_q.size() == 0) begin
          $error("noise_value: no item expected, actual %0d", $signed(m_axis_tdata[17:0]));
          fail_count <= fail_count + 1;
        end else begin
          want = noise_q.pop_front();
          if (m_axis_tdata[17:0] !== want) begin
            $error("noise_value: expected %0d actual %0d", $signed(want),
                   $signed(m_axis_tdata[17:0]));
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= noise_q.size();
    end
  end
endmodule

/* test/tb.sv */
// Testbench top: drives stimulus and seed writes, gives the verdict.
`timescale 1ns / 1ps
module tb import gn2d_pkg::*;;
  logic        clk_i = 0, rst_ni = 0;
  logic        s_axis_tvalid = 0, s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid, m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic        pready;
  int          fail_count, pending_count;
  bit          sink_on = 0;
  int          sink_wait = 0;

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  gradient_noise_2d dut (.*);
  gn2d_scoreboard chk (.*);

  task automatic write_seed(logic [31:0] s);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= RegSeed; pwdata <= s;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {y, x};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // Draw a wait after each output item and hold tready low while it counts down.
  always @(posedge clk_i) begin
    if (sink_on) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sink_wait = $urandom_range(0, 7);
        if (sink_wait != 0) m_axis_tready <= 1'b0;
      end else if (!m_axis_tready) begin
        sink_wait = sink_wait - 1;
        if (sink_wait <= 0) m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [31:0] seeds[5];
    logic [31:0] edges[8];
    seeds = '{32'h0, 32'hffffffff, 32'h1, 32'h8000_0000, 32'h0};
    edges = '{32'h0, 32'hffffffff, 32'h7fffffff, 32'h80000000,
              32'h0000ffff, 32'h00010000, 32'h00008000, 32'hffff8000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    sink_on <= 1;
    m_axis_tready <= 1;
    for (int p = 0; p < 5; p++) begin
      if (p == 4) seeds[p] = $urandom();
      write_seed(seeds[p]);
      if (p == 0) begin
        // corners of both fields, fractions at the rounding points, wrap of the lattice
        foreach (edges[i]) send_point(edges[i], edges[(i + 3) % 8]);
        foreach (edges[i]) send_point(edges[i], edges[i]);
        send_point(32'h0100_8000, 32'hff00_4000);
        send_point(32'h7fff_0001, 32'h8000_fffe);
      end
      for (int n = 0; n < 290; n++) begin
        case ($urandom_range(0, 3))
          0: send_point($urandom(), $urandom());
          1: send_point({$urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom_range(0, 3)),
                         16'($urandom())}, {16'($urandom_range(0, 511) - 256), 16'($urandom())});
          2: send_point({16'($urandom()), 16'($urandom_range(0, 15))},
                        {16'($urandom()), 16'hffff - 16'($urandom_range(0, 15))});
          default: send_point($urandom(), {16'($urandom()), 16'h8000});
        endcase
      end
      drain();
    end
    if (fail_count == 0)
      $display("gradient_noise_2d test passed");
    else
      $display("gradient_noise_2d test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("gradient_noise_2d test failed");
    $finish;
  end
endmodule

/* gradient_noise_2d.f */
rtl/gn2d_pkg.sv
rtl/gn2d_hash.sv
rtl/gn2d_fade.sv
rtl/gn2d_blend.sv
rtl/gradient_noise_2d.sv
rtl/gn2d_checker.sv
test/gn2d_checker.sv
test/tb.sv
